>>> design/sdrs_pkg.sv
// ----------------------------------------------------------------------------
// SCAN disk scheduler package
// Operation codes, geometry and configuration register indexes.
// ----------------------------------------------------------------------------
package sdrs_pkg;

  // Disk geometry and per-cell request limit
  localparam int TRACKS      = 32;
  localparam int SECTORS     = 8;
  localparam int MAX_PENDING = 15;

  // Request operation codes
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SERVE   = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SEEK_PER_TRACK     = 1'b0;
  localparam logic CFG_TRACK_CHANGE_EXTRA = 1'b1;

  // Register widths of the configuration port
  localparam int CFG_DATA_W = 4;

  // Result field widths
  localparam int ACC_OUT_W = 9;
  localparam int TOTAL_W   = 32;

endpackage

>>> design/sdrs_if.sv
// ----------------------------------------------------------------------------
// SCAN disk scheduler channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdrs_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [4:0] req_track;
  logic [2:0] req_sector;

  modport source (output valid, output operation, output req_track, output req_sector,
                  input ready);
  modport sink (input valid, input operation, input req_track, input req_sector,
                output ready);
endinterface

interface sdrs_rsp_if;
  logic        valid;
  logic        ready;
  logic        served;
  logic [4:0]  srv_track;
  logic [2:0]  srv_sector;
  logic [8:0]  access_half_ms;
  logic [31:0] total_half_ms;
  logic [31:0] total_arm_move;
  logic        enqueue_full;
  logic        all_empty;

  modport source (output valid, output served, output srv_track, output srv_sector,
                  output access_half_ms, output total_half_ms, output total_arm_move,
                  output enqueue_full, output all_empty, input ready);
  modport sink (input valid, input served, input srv_track, input srv_sector,
                input access_half_ms, input total_half_ms, input total_arm_move,
                input enqueue_full, input all_empty, output ready);
endinterface

>>> design/scan_disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// SCAN disk request scheduler
// Elevator scheduling of pending (track, sector) requests.
// ----------------------------------------------------------------------------
// Usage: requests enter on req (valid/ready). An enqueue request adds one
// pending access to a cell; a serve request picks the next access in SCAN
// order and reports its access time and the running totals. Every request
// gives exactly one result on rsp (valid/ready).
// Sequence, from the accepting edge to rsp.valid: an enqueue passes
// ST_RMW and ST_DONE; a serve with nothing pending goes straight to
// ST_DONE; any other serve passes ST_START, then ST_SCAN if the head track
// has no work (the sweep scanner walks one track per cycle and reverses at
// the end of travel), then ST_PICK, ST_RMW (read-modify-write of the count
// memory) and ST_DONE, which raises rsp.valid once the output register frees.
// Throughput: one request at a time; req is ready in the idle state, also
// while a result still waits in the output register.
// Stall: when rsp is not taken, the finished result holds and the next
// request waits in its last state until the output register frees.
// Reset: rst clears the occupancy bits, the head, the totals and the config
// registers to their defaults; counts in memory are masked by the occupancy
// bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module scan_disk_request_scheduler
  import sdrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sdrs_req_if.sink              req,
  sdrs_rsp_if.source            rsp
);

  localparam int TW    = $clog2(TRACKS);
  localparam int SW    = $clog2(SECTORS);
  localparam int CW    = $clog2(MAX_PENDING + 1);
  localparam int CELLS = TRACKS * SECTORS;
  localparam int AW    = $clog2(CELLS);
  localparam int NCW   = $clog2(CELLS + 1);
  localparam int ACW   = TW + SW + 6;

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_SCAN, ST_PICK, ST_RMW, ST_DONE
  } state_t;

  state_t state;

  // Configuration
  logic [3:0] seek_per_track;
  logic [3:0] track_change_extra;

  // Scheduler state
  logic [SECTORS-1:0] nz [TRACKS];
  logic [NCW-1:0]     nz_count;
  logic [TW-1:0]      head_track;
  logic [SW-1:0]      head_sector;
  logic               sweep_up;
  logic [31:0]        time_total;
  logic [31:0]        move_total;

  // Working registers
  logic               is_enq;
  logic [TW-1:0]      scan_t;
  logic [TW-1:0]      target;
  logic [TW-1:0]      cell_t;
  logic [SW-1:0]      cell_s;
  logic [AW-1:0]      cell_addr;
  logic [ACW-1:0]     acc_r;
  logic [TW-1:0]      dist_r;
  logic               r_served;
  logic               r_full;

  // Memory ports
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic          mem_wr_en;
  logic [CW-1:0] mem_wr_data;
  logic [CW-1:0] mem_q;

  // Combinational helpers
  logic               enq_in_range;
  logic [AW-1:0]      enq_addr;
  logic               start_up;
  logic               head_busy;
  logic               scan_busy;
  logic [SECTORS-1:0] row;
  logic               same_track;
  logic [SW-1:0]      pk_s;
  logic [ACW-1:0]     pk_k;
  logic [TW-1:0]      pk_dist;
  logic [ACW-1:0]     pk_acc;
  logic [AW-1:0]      pk_addr;
  logic [CW-1:0]      cur_count;
  logic [32:0]        time_sum;
  logic [32:0]        move_sum;
  logic               out_free;

  sdrs_count_mem #(.DEPTH(CELLS), .WIDTH(CW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (cell_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_q)
  );

  // Decode the incoming enqueue cell
  assign enq_in_range = (32'(req.req_track) < TRACKS) && (32'(req.req_sector) < SECTORS);
  assign enq_addr     = AW'(32'(req.req_track) * SECTORS + 32'(req.req_sector));

  // Sweep direction after the end-of-travel turn
  always_comb begin
    start_up = sweep_up;
    if (head_track >= TW'(TRACKS - 1)) begin
      start_up = 1'b0;
    end
    if (head_track == '0) begin
      start_up = 1'b1;
    end
  end

  assign head_busy = |nz[head_track];
  assign scan_busy = |nz[scan_t];

  // Pick the sector on the target track
  always_comb begin
    logic [SW:0] c;
    logic        found;
    row        = nz[target];
    same_track = (target == head_track);
    pk_s       = '0;
    pk_k       = ACW'(SECTORS);
    found      = 1'b0;
    c          = '0;
    if (same_track) begin
      for (int k = 1; k <= SECTORS; k++) begin
        c = (SW + 1)'(head_sector) + (SW + 1)'(k);
        if (c >= (SW + 1)'(SECTORS)) begin
          c = c - (SW + 1)'(SECTORS);
        end
        if (!found && row[c[SW-1:0]]) begin
          found = 1'b1;
          pk_s  = c[SW-1:0];
          pk_k  = ACW'(k);
        end
      end
    end else begin
      for (int k = 0; k < SECTORS; k++) begin
        if (!found && row[k]) begin
          found = 1'b1;
          pk_s  = SW'(k);
        end
      end
    end
    pk_dist = (target > head_track) ? (target - head_track) : (head_track - target);
    if (same_track) begin
      pk_dist = '0;
      pk_acc  = pk_k;
    end else begin
      pk_acc = ACW'(pk_dist) * ACW'(seek_per_track) + ACW'(pk_s) + ACW'(track_change_extra);
    end
    pk_addr = AW'(32'(target) * SECTORS + 32'(pk_s));
  end

  // Count of the addressed cell, masked by its occupancy bit
  assign cur_count = nz[cell_t][cell_s] ? mem_q : '0;

  assign time_sum = {1'b0, time_total} + 33'(acc_r);
  assign move_sum = {1'b0, move_total} + 33'(dist_r);

  // Drive the count memory
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = pk_addr;
    mem_wr_en   = 1'b0;
    mem_wr_data = cur_count + CW'(1);
    if (state == ST_IDLE) begin
      mem_rd_en   = req.valid && (req.operation == OP_ENQUEUE);
      mem_rd_addr = enq_addr;
    end else if (state == ST_PICK) begin
      mem_rd_en = 1'b1;
    end
    if (state == ST_RMW) begin
      if (is_enq) begin
        mem_wr_en = (32'(cur_count) < MAX_PENDING);
      end else begin
        mem_wr_en   = 1'b1;
        mem_wr_data = cur_count - CW'(1);
      end
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      seek_per_track     <= 4'd2;
      track_change_extra <= 4'd1;
      nz                 <= '{default: '0};
      nz_count           <= '0;
      head_track         <= '0;
      head_sector        <= '0;
      sweep_up           <= 1'b1;
      time_total         <= '0;
      move_total         <= '0;
      rsp.valid          <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        if (cfg_index == CFG_SEEK_PER_TRACK) begin
          seek_per_track <= cfg_data;
        end else begin
          track_change_extra <= cfg_data;
        end
      end

      // Release a taken result unless the next one loads in its place
      if (rsp.valid && rsp.ready && (state != ST_DONE)) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            is_enq   <= (req.operation == OP_ENQUEUE);
            r_served <= 1'b0;
            r_full   <= 1'b0;
            acc_r    <= '0;
            dist_r   <= '0;
            target   <= '0;
            if (req.operation == OP_ENQUEUE) begin
              cell_t    <= TW'(req.req_track);
              cell_s    <= SW'(req.req_sector);
              cell_addr <= enq_addr;
              state     <= enq_in_range ? ST_RMW : ST_DONE;
            end else begin
              state <= (nz_count == '0) ? ST_DONE : ST_START;
            end
          end
        end
        ST_START: begin
          sweep_up <= start_up;
          if (head_busy) begin
            target <= head_track;
            state  <= ST_PICK;
          end else begin
            scan_t <= start_up ? (head_track + TW'(1)) : (head_track - TW'(1));
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Walk one track per cycle; reverse at the end of travel
          if (scan_busy) begin
            target <= scan_t;
            state  <= ST_PICK;
          end else if (sweep_up ? (scan_t == TW'(TRACKS - 1)) : (scan_t == '0)) begin
            sweep_up <= !sweep_up;
            scan_t   <= sweep_up ? (head_track - TW'(1)) : (head_track + TW'(1));
          end else begin
            scan_t <= sweep_up ? (scan_t + TW'(1)) : (scan_t - TW'(1));
          end
        end
        ST_PICK: begin
          cell_t    <= target;
          cell_s    <= pk_s;
          cell_addr <= pk_addr;
          acc_r     <= pk_acc;
          dist_r    <= pk_dist;
          state     <= ST_RMW;
        end
        ST_RMW: begin
          if (is_enq) begin
            if (32'(cur_count) >= MAX_PENDING) begin
              r_full <= 1'b1;
            end else begin
              nz[cell_t][cell_s] <= 1'b1;
              if (cur_count == '0) begin
                nz_count <= nz_count + NCW'(1);
              end
            end
          end else begin
            if (cur_count == CW'(1)) begin
              nz[cell_t][cell_s] <= 1'b0;
              nz_count           <= nz_count - NCW'(1);
            end
            head_track  <= cell_t;
            head_sector <= cell_s;
            time_total  <= time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
            move_total  <= move_sum[32] ? 32'hFFFF_FFFF : move_sum[31:0];
            r_served    <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          // Load the result register once it is free
          if (out_free) begin
            rsp.valid          <= 1'b1;
            rsp.served         <= r_served;
            rsp.srv_track      <= r_served ? 5'(cell_t) : 5'd0;
            rsp.srv_sector     <= r_served ? 3'(cell_s) : 3'd0;
            rsp.access_half_ms <= (acc_r > ACW'(511)) ? 9'd511 : ACC_OUT_W'(acc_r);
            rsp.total_half_ms  <= time_total;
            rsp.total_arm_move <= move_total;
            rsp.enqueue_full   <= r_full;
            rsp.all_empty      <= (nz_count == '0);
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/sdrs_count_mem.sv
// ----------------------------------------------------------------------------
// Pending count memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sdrs_count_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
